// ===== sv/gdsd_pkg.sv =====
// Types, constants and calendar tables shared by the date span core.
package gdsd_pkg;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int ORD_W   = 23;
   localparam int COUNT_W = 22;
   localparam int DOY_W   = 9;
   localparam int QUOT_W  = 8;

   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [8:0]  DAYS_YEAR   = 9'd365;

   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FEB_COMMON = 5'd28;
   localparam logic [DAY_W-1:0]   DAY_FEB_LEAP   = 5'd29;

   typedef enum logic [1:0] {
      DATE_OK    = 2'd0,
      DATE_MONTH = 2'd1,
      DATE_DAY   = 2'd2,
      DATE_FEB29 = 2'd3
   } date_check_type;

   typedef enum logic [2:0] {
      STATUS_OK          = 3'd0,
      STATUS_START_MONTH = 3'd1,
      STATUS_START_DAY   = 3'd2,
      STATUS_START_FEB29 = 3'd3,
      STATUS_END_MONTH   = 3'd4,
      STATUS_END_DAY     = 3'd5,
      STATUS_END_FEB29   = 3'd6,
      STATUS_ORDER       = 3'd7
   } status_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  from_year;
      logic [MONTH_W-1:0] from_month;
      logic [DAY_W-1:0]   from_day;
      logic [YEAR_W-1:0]  to_year;
      logic [MONTH_W-1:0] to_month;
      logic [DAY_W-1:0]   to_day;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [COUNT_W-1:0] day_count;
   } rsp_type;

   function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                   len = 5'd30;
         4'd2:                                      len = 5'd28;
         default:                                   len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [DOY_W-1:0] days_before_month(input logic [MONTH_W-1:0] m);
      logic [DOY_W-1:0] days;
      case (m)
         4'd1:    days = 9'd0;
         4'd2:    days = 9'd31;
         4'd3:    days = 9'd59;
         4'd4:    days = 9'd90;
         4'd5:    days = 9'd120;
         4'd6:    days = 9'd151;
         4'd7:    days = 9'd181;
         4'd8:    days = 9'd212;
         4'd9:    days = 9'd243;
         4'd10:   days = 9'd273;
         4'd11:   days = 9'd304;
         4'd12:   days = 9'd334;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

   function automatic status_type merge_status(input date_check_type s_chk,
                                               input date_check_type e_chk);
      status_type st;
      case (s_chk)
         DATE_MONTH: st = STATUS_START_MONTH;
         DATE_DAY:   st = STATUS_START_DAY;
         DATE_FEB29: st = STATUS_START_FEB29;
         default: begin
            case (e_chk)
               DATE_MONTH: st = STATUS_END_MONTH;
               DATE_DAY:   st = STATUS_END_DAY;
               DATE_FEB29: st = STATUS_END_FEB29;
               default:    st = STATUS_OK;
            endcase
         end
      endcase
      return st;
   endfunction

endpackage

// ===== sv/gregorian_date_span_days_core.sv =====
// Top level of the Gregorian date span core: day count between two dates.
//
// Usage: drive a start and an end date on req_data and pulse start. A beat is
// taken at every rising edge where start is high and busy is low; busy is
// high only while reset is asserted, so one beat can be taken every cycle.
// Each beat gives exactly one result beat on rsp_data, marked by rsp_strobe
// for one cycle. The request passes through the input register, the ordinal
// register and the result register, and the strobe comes from the last.
// Results leave in the order the requests arrived. Throughput is one
// beat per cycle, set by the three-stage pipeline with no shared units.
// The receiver cannot stall the result channel, so no result ever waits.
// Status is nonzero for a bad month or day in either date, Feb 29 in a
// common year, or an end date before the start date; day_count is then 0.
// Spans above the day total of years 0 to MAX_YEAR saturate at that total.
// Synchronous reset empties the pipeline; beats in flight are dropped.
module gregorian_date_span_days_core #(
   parameter int MAX_YEAR = 9999
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  gdsd_pkg::req_type req_data,
   output logic              rsp_strobe,
   output gdsd_pkg::rsp_type rsp_data
);
   import gdsd_pkg::*;

   localparam int LimitRaw = 365 * (MAX_YEAR + 1) + (MAX_YEAR + 4) / 4
                           - (MAX_YEAR + 100) / 100 + (MAX_YEAR + 400) / 400;
   localparam int CountMax = (1 << COUNT_W) - 1;
   localparam int LimitInt = (LimitRaw > CountMax) ? CountMax : LimitRaw;
   localparam logic [COUNT_W-1:0] CountLimit = COUNT_W'(LimitInt);

   logic             accept;
   req_type          req_ff;
   logic             req_valid_ff;
   date_check_type   start_check;
   date_check_type   end_check;
   logic [ORD_W-1:0] start_ord;
   logic [ORD_W-1:0] end_ord;
   status_type       pre_status_in;
   status_type       pre_status_ff;
   logic [ORD_W-1:0] start_ord_ff;
   logic [ORD_W-1:0] end_ord_ff;
   logic             ord_valid_ff;
   logic [ORD_W-1:0] span;
   rsp_type          rsp_in;
   rsp_type          rsp_ff;
   logic             rsp_strobe_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= accept;
      end
      if (accept) begin
         req_ff <= req_data;
      end
   end

   gdsd_date_unit u_start_date (
      .year    (req_ff.from_year),
      .month   (req_ff.from_month),
      .day     (req_ff.from_day),
      .check   (start_check),
      .ordinal (start_ord)
   );

   gdsd_date_unit u_end_date (
      .year    (req_ff.to_year),
      .month   (req_ff.to_month),
      .day     (req_ff.to_day),
      .check   (end_check),
      .ordinal (end_ord)
   );

   assign pre_status_in = merge_status(start_check, end_check);

   always_ff @(posedge clock) begin
      if (reset) begin
         ord_valid_ff <= 1'b0;
      end else begin
         ord_valid_ff <= req_valid_ff;
      end
      pre_status_ff <= pre_status_in;
      start_ord_ff  <= start_ord;
      end_ord_ff    <= end_ord;
   end

   assign span = end_ord_ff - start_ord_ff;

   always_comb begin
      rsp_in.status    = pre_status_ff;
      rsp_in.day_count = '0;
      if (pre_status_ff == STATUS_OK) begin
         if (end_ord_ff < start_ord_ff) begin
            rsp_in.status = STATUS_ORDER;
         end else if (span > ORD_W'(CountLimit)) begin
            rsp_in.day_count = CountLimit;
         end else begin
            rsp_in.day_count = span[COUNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= ord_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

`ifndef NO_ASSERTIONS
   a_latency : assert property (@(posedge clock) disable iff (reset)
      accept |=> ##2 rsp_strobe)
      else $error("accepted beat did not give a result three cycles later");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3))
      else $error("result beat without a matching request beat");

   a_zero_on_error : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.status != STATUS_OK)) |-> (rsp_data.day_count == '0))
      else $error("nonzero day count with an error status");

   a_saturated : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.day_count <= CountLimit))
      else $error("day count above the saturation limit");
`endif

endmodule

// ===== sv/gdsd_date_unit.sv =====
// Checks one calendar date and forms its ordinal day number.
module gdsd_date_unit (
   input  logic [gdsd_pkg::YEAR_W-1:0]  year,
   input  logic [gdsd_pkg::MONTH_W-1:0] month,
   input  logic [gdsd_pkg::DAY_W-1:0]   day,
   output gdsd_pkg::date_check_type     check,
   output logic [gdsd_pkg::ORD_W-1:0]   ordinal
);
   import gdsd_pkg::*;

   logic [26:0]         prod_floor;
   logic [27:0]         prod_ceil;
   logic [YEAR_W:0]     year_p99;
   logic [YEAR_W:0]     year_p3;
   logic [QUOT_W-1:0]   floor100;
   logic [QUOT_W-1:0]   ceil100;
   logic [QUOT_W:0]     ceil100_p3;
   logic                leap;
   logic [ORD_W-1:0]    days_before_year;
   logic [DOY_W-1:0]    day_of_year;

   // Exact for every 15-bit operand: the reciprocal error stays below one step.
   assign prod_floor = 27'(year) * 27'(RECIP_100);
   assign year_p99   = (YEAR_W+1)'(year) + (YEAR_W+1)'(99);
   assign prod_ceil  = 28'(year_p99) * 28'(RECIP_100);
   assign floor100   = prod_floor[RECIP_SHIFT +: QUOT_W];
   assign ceil100    = prod_ceil[RECIP_SHIFT +: QUOT_W];
   assign ceil100_p3 = (QUOT_W+1)'(ceil100) + (QUOT_W+1)'(3);
   assign year_p3    = (YEAR_W+1)'(year) + (YEAR_W+1)'(3);

   // A century year has equal floor and ceiling quotients by one hundred.
   assign leap = (year[1:0] == 2'b00) &&
                 ((floor100 != ceil100) || (floor100[1:0] == 2'b00));

   assign days_before_year = ORD_W'(year) * ORD_W'(DAYS_YEAR)
                           + ORD_W'(year_p3[YEAR_W:2])
                           - ORD_W'(ceil100)
                           + ORD_W'(ceil100_p3[QUOT_W:2]);

   assign day_of_year = days_before_month(month) + DOY_W'(day)
                      + DOY_W'((month > MONTH_FEB) && leap);

   assign ordinal = days_before_year + ORD_W'(day_of_year);

   always_comb begin
      if ((month < MONTH_JAN) || (month > MONTH_DEC)) begin
         check = DATE_MONTH;
      end else if (day == '0) begin
         check = DATE_DAY;
      end else if (month == MONTH_FEB) begin
         if (day <= DAY_FEB_COMMON) begin
            check = DATE_OK;
         end else if (day == DAY_FEB_LEAP) begin
            check = leap ? DATE_OK : DATE_FEB29;
         end else begin
            check = DATE_DAY;
         end
      end else if (day <= month_length(month)) begin
         check = DATE_OK;
      end else begin
         check = DATE_DAY;
      end
   end

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the Gregorian date span core: directed and random date pairs.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import gdsd_pkg::*;

   class date_span_scoreboard;
      int unsigned max_year = 9999;
      rsp_type     span_queue[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function bit is_leap(int unsigned y);
         return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
      endfunction

      function int unsigned month_days(int unsigned y, int unsigned m);
         int unsigned len;
         case (m)
            1, 3, 5, 7, 8, 10, 12: len = 31;
            4, 6, 9, 11:           len = 30;
            2:                     len = is_leap(y) ? 29 : 28;
            default:               len = 0;
         endcase
         return len;
      endfunction

      function int unsigned days_ahead_of_year(int unsigned y);
         return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
      endfunction

      function int unsigned day_number(int unsigned y, int unsigned m, int unsigned d);
         int unsigned n;
         n = days_ahead_of_year(y) + d;
         for (int unsigned k = 1; k < m; k++) n += month_days(y, k);
         return n;
      endfunction

      function date_check_type date_verdict(int unsigned y, int unsigned m, int unsigned d);
         if (m < 1 || m > 12) return DATE_MONTH;
         if (d == 0) return DATE_DAY;
         if (m == 2 && d == 29 && !is_leap(y)) return DATE_FEB29;
         if (d > month_days(y, m)) return DATE_DAY;
         return DATE_OK;
      endfunction

      function rsp_type predict_span(req_type r);
         rsp_type        e;
         date_check_type sv;
         date_check_type ev;
         int unsigned    so;
         int unsigned    eo;
         int unsigned    cap;
         e.status    = STATUS_OK;
         e.day_count = '0;
         sv = date_verdict(r.from_year, r.from_month, r.from_day);
         ev = date_verdict(r.to_year, r.to_month, r.to_day);
         if (sv == DATE_MONTH) e.status = STATUS_START_MONTH;
         else if (sv == DATE_DAY) e.status = STATUS_START_DAY;
         else if (sv == DATE_FEB29) e.status = STATUS_START_FEB29;
         else if (ev == DATE_MONTH) e.status = STATUS_END_MONTH;
         else if (ev == DATE_DAY) e.status = STATUS_END_DAY;
         else if (ev == DATE_FEB29) e.status = STATUS_END_FEB29;
         else begin
            so = day_number(r.from_year, r.from_month, r.from_day);
            eo = day_number(r.to_year, r.to_month, r.to_day);
            if (eo < so) begin
               e.status = STATUS_ORDER;
            end else begin
               cap = days_ahead_of_year(max_year + 1);
               if (cap > 32'h3F_FFFF) cap = 32'h3F_FFFF;
               e.day_count = COUNT_W'((eo - so > cap) ? cap : eo - so);
            end
         end
         return e;
      endfunction

      function void note_request(req_type r);
         span_queue.push_back(predict_span(r));
      endfunction

      function void check_result(rsp_type got);
         rsp_type exp;
         if (span_queue.size() == 0) begin
            $error("result beat with no request outstanding: status %0d, day_count %0d",
                   got.status, got.day_count);
            mismatches++;
            return;
         end
         exp = span_queue.pop_front();
         if (got.status !== exp.status) begin
            $error("status mismatch: expected %0d, actual %0d", exp.status, got.status);
            mismatches++;
         end
         if (got.day_count !== exp.day_count) begin
            $error("day_count mismatch: expected %0d, actual %0d",
                   exp.day_count, got.day_count);
            mismatches++;
         end
      endfunction

      function int unsigned pending();
         return span_queue.size();
      endfunction
   endclass

   localparam int RANDOM_BEATS = 700;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int YEAR_TOP     = 16383;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      cycles = 0;

   date_span_scoreboard sb = new();

   gregorian_date_span_days_core dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else if (!reset && rsp_strobe) begin
         sb.check_result(rsp_data);
      end
   end

   function automatic req_type make_req(int unsigned sy, int unsigned sm, int unsigned sd,
                                        int unsigned ey, int unsigned em, int unsigned ed);
      req_type r;
      r.from_year  = YEAR_W'(sy);
      r.from_month = MONTH_W'(sm);
      r.from_day   = DAY_W'(sd);
      r.to_year    = YEAR_W'(ey);
      r.to_month   = MONTH_W'(em);
      r.to_day     = DAY_W'(ed);
      return r;
   endfunction

   function automatic req_type noise_req();
      return make_req($urandom_range(0, YEAR_TOP), $urandom_range(0, 15), $urandom_range(0, 31),
                      $urandom_range(0, YEAR_TOP), $urandom_range(0, 15), $urandom_range(0, 31));
   endfunction

   function automatic int unsigned random_year();
      int unsigned pick;
      pick = $urandom_range(0, 3);
      if (pick == 0) return $urandom_range(0, YEAR_TOP);
      if (pick == 3) return $urandom_range(1600, 2400);
      return $urandom_range(0, 9999);
   endfunction

   function automatic void spoil_date(input int unsigned kind,
                                      inout int unsigned y, inout int unsigned m,
                                      inout int unsigned d);
      case (kind)
         0: begin
            m = $urandom_range(12, 15);
            if (m == 12) m = 0;
            d = $urandom_range(0, 31);
         end
         1: begin
            if ($urandom_range(0, 1) == 0) begin
               d = 0;
            end else begin
               m = $urandom_range(0, 1) ? 2 : 4 + 2 * $urandom_range(0, 1);
               d = $urandom_range(sb.month_days(y, m) + 1, 31);
            end
         end
         default: begin
            if (sb.is_leap(y)) y = (y == YEAR_TOP) ? y - 1 : y + 1;
            m = 2;
            d = 29;
         end
      endcase
   endfunction

   function automatic req_type random_item();
      int unsigned pick;
      int unsigned sy, sm, sd, ey, em, ed;
      pick = $urandom_range(0, 99);
      if (pick >= 90) return noise_req();
      sy = random_year();
      sm = $urandom_range(1, 12);
      sd = $urandom_range(1, sb.month_days(sy, sm));
      case ($urandom_range(0, 2))
         0:       ey = sy;
         1:       ey = (sy + 3 > YEAR_TOP) ? sy : sy + $urandom_range(0, 3);
         default: ey = $urandom_range(sy, YEAR_TOP);
      endcase
      if (pick >= 60 && pick < 75) ey = random_year();
      em = $urandom_range(1, 12);
      ed = $urandom_range(1, sb.month_days(ey, em));
      if (pick < 60 && ey == sy && (em < sm || (em == sm && ed < sd))) begin
         {em, sm} = {sm, em};
         {ed, sd} = {sd, ed};
      end
      if (pick >= 75) begin
         pick = $urandom_range(0, 5);
         if (pick < 3) spoil_date(pick, sy, sm, sd);
         else spoil_date(pick - 3, ey, em, ed);
      end
      return make_req(sy, sm, sd, ey, em, ed);
   endfunction

   task automatic send_beat(req_type r);
      req_data <= r;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(r);
   endtask

   task automatic idle_gap(int unsigned n);
      start    <= 1'b0;
      req_data <= noise_req();
      repeat (n) @(posedge clock);
   endtask

   initial begin
      int sent;
      int burst;
      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_beat(make_req(0, 1, 1, 0, 1, 1));
      send_beat(make_req(0, 1, 1, 9999, 12, 31));
      send_beat(make_req(0, 1, 1, YEAR_TOP, 12, 31));
      send_beat(make_req(YEAR_TOP, 12, 31, YEAR_TOP, 12, 31));
      send_beat(make_req(YEAR_TOP, 12, 31, 0, 1, 1));
      send_beat(make_req(2020, 0, 10, 2021, 1, 1));
      send_beat(make_req(2020, 13, 0, 2021, 1, 1));
      send_beat(make_req(YEAR_TOP, 15, 31, YEAR_TOP, 15, 31));
      send_beat(make_req(2020, 3, 0, 2021, 0, 0));
      send_beat(make_req(2001, 2, 29, 2002, 1, 1));
      send_beat(make_req(2000, 2, 30, 2002, 1, 1));
      send_beat(make_req(2000, 2, 29, 2004, 2, 29));
      send_beat(make_req(0, 2, 29, 400, 2, 29));
      send_beat(make_req(2000, 1, 1, 2001, 14, 5));
      send_beat(make_req(2000, 1, 1, 2001, 6, 0));
      send_beat(make_req(2000, 1, 1, 2001, 4, 31));
      send_beat(make_req(1896, 1, 1, 1900, 2, 29));
      send_beat(make_req(2020, 5, 10, 2020, 5, 9));
      send_beat(make_req(2021, 1, 1, 2020, 12, 31));
      send_beat(make_req(12000, 1, 1, 12000, 3, 1));
      send_beat(make_req(9999, 12, 31, 10000, 1, 1));
      send_beat(make_req(1999, 12, 31, 2000, 2, 31));
      send_beat(make_req(2023, 11, 30, 2024, 12, 31));

      sent = 0;
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 20);
         for (int k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
            send_beat(random_item());
            sent++;
         end
         if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 6));
      end

      start <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule

// ===== filelist.f =====
sv/gdsd_pkg.sv
sv/gdsd_date_unit.sv
sv/gregorian_date_span_days_core.sv
verif/testbench.sv
